/* hdl/quadratic_positive_root_solver_core_defines.svh */
// Assertion macros shared by the quadratic root solver.
`ifndef QUADRATIC_POSITIVE_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_POSITIVE_ROOT_SOLVER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPRS_ASSERT_SAME(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("qprs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QPRS_ASSERT_NEXT(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("qprs: next-cycle check failed");

`endif

/* hdl/qprs_pkg.sv */
package qprs_pkg;

  localparam int PW    = 24;  // half linear coefficient, Q12.12
  localparam int QW    = 48;  // constant term, Q24.24
  localparam int TolW  = 16;  // tolerance, Q4.12
  localparam int RadW  = 48;  // square root operand
  localparam int SqrtW = 24;  // square root result
  localparam int PpW   = 47;  // p*p magnitude
  localparam int DelW  = 50;  // signed discriminant with headroom
  localparam int CandW = 26;  // signed root candidate
  localparam int RootW = 25;  // packed root
  localparam int CntW  = 2;

  localparam logic [TolW-1:0] TolReset = 16'd1;
  localparam logic [CntW-1:0] MaxRoots = 2'd2;

  // Data that travels beside the square root pipeline.
  typedef struct packed {
    logic                 ok;  // discriminant reached the tolerance
    logic signed [PW-1:0] p;
  } qprs_side_t;

  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [RootW-1:0] root_a;
    logic [RootW-1:0] root_b;
  } qprs_result_t;

endpackage

/* hdl/quadratic_positive_root_solver_core.sv */
// Structure: an item passes 28 registers (two discriminant stages, 24 square root stages,
//   one packing stage and the output register), and the first of them is loaded at the
//   transfer edge itself.
// Throughput: one item per cycle while the output skid stage is empty. The pipeline is
//   frozen while the skid stage holds an entry.
// Reset (rst, synchronous, active high) empties the pipeline and sets tolerance to 1.
`include "quadratic_positive_root_solver_core_defines.svh"

module quadratic_positive_root_solver_core
  import qprs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // Tolerance register write port.
  input  logic                    cfg_we,
  input  logic [TolW-1:0]         cfg_wdata,
  // Input channel.
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PW-1:0]    half_linear,
  input  logic signed [QW-1:0]    constant_term,
  // Output channel.
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CntW-1:0]         root_count,
  output logic [RootW-1:0]        root_a,
  output logic [RootW-1:0]        root_b
);

  // The user must write the tolerance only while the block is idle (the block does not
  // enforce this), so every stage may read the live register value.
  logic [TolW-1:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TolReset;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // The whole pipeline moves on one enable. It only stops when the skid stage
  // holds an item, which keeps the stall path from the output to the input
  // fully registered. The output register and the skid stage together absorb
  // the one item that is still in flight when the consumer stalls.
  logic                 en;
  logic                 disc_valid;
  logic [RadW-1:0]      disc_rad;
  qprs_side_t           disc_side;
  logic                 sqrt_valid;
  logic [SqrtW-1:0]     sqrt_root;
  qprs_side_t           sqrt_side;
  logic                 pack_valid;
  qprs_result_t         pack_res;

  logic                 skid_valid;
  qprs_result_t         skid_res;
  qprs_result_t         out_res;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Discriminant: p*p in the first stage, delta and the tolerance test in the second.
  qprs_disc u_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (in_valid),
    .p_in      (half_linear),
    .q_in      (constant_term),
    .tolerance (tolerance),
    .valid_out (disc_valid),
    .rad_out   (disc_rad),
    .side_out  (disc_side)
  );

  // Floor square root of delta, one result bit per stage.
  qprs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (disc_valid),
    .rad_in    (disc_rad),
    .side_in   (disc_side),
    .valid_out (sqrt_valid),
    .root_out  (sqrt_root),
    .side_out  (sqrt_side)
  );

  // Candidate roots -p-d and -p+d, tested against the tolerance and packed.
  qprs_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (sqrt_valid),
    .d_in      (sqrt_root),
    .side_in   (sqrt_side),
    .tolerance (tolerance),
    .valid_out (pack_valid),
    .res_out   (pack_res)
  );

  // Output register with a one-entry skid stage behind it. When the output
  // register is held by a stalled transfer, an arriving item parks in the skid
  // stage. Once the output frees up, the skid entry moves forward first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (en && pack_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= pack_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (en && pack_valid) begin
        skid_res <= pack_res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else begin
      out_res <= pack_res;
    end
  end

  assign root_count = out_res.count;
  assign root_a     = out_res.root_a;
  assign root_b     = out_res.root_b;

  // An item only waits in the skid stage behind a held output register.
  `QPRS_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // A skid entry leaves as soon as the output transfer completes.
  `QPRS_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && !out_stall, !skid_valid)
  // No result reports more than two roots.
  `QPRS_ASSERT_SAME(a_count_range, clk, rst, out_valid, root_count <= MaxRoots)
  // A result with no roots carries zero in both slots.
  `QPRS_ASSERT_SAME(a_empty_slots, clk, rst, out_valid && (root_count == '0),
                    (root_a == '0) && (root_b == '0))

endmodule

/* hdl/qprs_disc.sv */
module qprs_disc
  import qprs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic signed [PW-1:0] p_in,
  input  logic signed [QW-1:0] q_in,
  input  logic [TolW-1:0]      tolerance,
  output logic                 valid_out,
  output logic [RadW-1:0]      rad_out,
  output qprs_side_t           side_out
);

  // First stage: square of p.
  logic                     sq_valid;
  logic [PpW-1:0]           sq_pp;
  logic signed [QW-1:0]     sq_q;
  logic signed [PW-1:0]     sq_p;
  logic signed [2*PW-1:0]   prod;

  // Second stage: discriminant and threshold compare.
  logic signed [DelW-1:0]   delta;
  logic signed [DelW-1:0]   thresh;
  logic                     ok;

  assign prod   = p_in * p_in;
  assign delta  = $signed({3'b000, sq_pp}) - $signed({{(DelW-QW){sq_q[QW-1]}}, sq_q});
  assign thresh = $signed({{(DelW-TolW-12){1'b0}}, tolerance, 12'd0});
  assign ok     = (delta >= thresh);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      sq_valid  <= valid_in;
      valid_out <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_pp       <= prod[PpW-1:0];
      sq_q        <= q_in;
      sq_p        <= p_in;
      rad_out     <= ok ? delta[RadW-1:0] : '0;
      side_out.ok <= ok;
      side_out.p  <= sq_p;
    end
  end

endmodule

/* hdl/qprs_sqrt_stage.sv */
module qprs_sqrt_stage
  import qprs_pkg::*;
#(
  parameter int Bit = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  logic [RadW-1:0]  rem_in,
  input  logic [SqrtW-1:0] root_in,
  input  qprs_side_t       side_in,
  output logic             valid_out,
  output logic [RadW-1:0]  rem_out,
  output logic [SqrtW-1:0] root_out,
  output qprs_side_t       side_out
);

  // Setting this bit grows root^2 by root*2^(Bit+1) + 2^(2*Bit).
  logic [RadW+1:0] trial;
  logic            take;

  assign trial = ({{(RadW+2-SqrtW){1'b0}}, root_in} << (Bit + 1))
               + ({{(RadW+1){1'b0}}, 1'b1} << (2 * Bit));
  assign take  = ({2'b00, rem_in} >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? (rem_in - trial[RadW-1:0]) : rem_in;
      root_out <= take ? (root_in | (SqrtW'(1) << Bit)) : root_in;
      side_out <= side_in;
    end
  end

endmodule

/* hdl/qprs_sqrt.sv */
module qprs_sqrt
  import qprs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  logic [RadW-1:0]  rad_in,
  input  qprs_side_t       side_in,
  output logic             valid_out,
  output logic [SqrtW-1:0] root_out,
  output qprs_side_t       side_out
);

  // One result bit per stage, most significant bit first.
  logic             valid_c [SqrtW+1];
  logic [RadW-1:0]  rem_c   [SqrtW+1];
  logic [SqrtW-1:0] root_c  [SqrtW+1];
  qprs_side_t       side_c  [SqrtW+1];

  assign valid_c[0] = valid_in;
  assign rem_c[0]   = rad_in;
  assign root_c[0]  = '0;
  assign side_c[0]  = side_in;

  for (genvar s = 0; s < SqrtW; s++) begin : g_stage
    qprs_sqrt_stage #(
      .Bit(SqrtW - 1 - s)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (valid_c[s]),
      .rem_in    (rem_c[s]),
      .root_in   (root_c[s]),
      .side_in   (side_c[s]),
      .valid_out (valid_c[s+1]),
      .rem_out   (rem_c[s+1]),
      .root_out  (root_c[s+1]),
      .side_out  (side_c[s+1])
    );
  end

  assign valid_out = valid_c[SqrtW];
  assign root_out  = root_c[SqrtW];
  assign side_out  = side_c[SqrtW];

endmodule

/* hdl/qprs_pack.sv */
module qprs_pack
  import qprs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  logic [SqrtW-1:0] d_in,
  input  qprs_side_t       side_in,
  input  logic [TolW-1:0]  tolerance,
  output logic             valid_out,
  output qprs_result_t     res_out
);

  logic signed [CandW-1:0] neg_p;
  logic signed [CandW-1:0] d_ext;
  logic signed [CandW-1:0] tol_ext;
  logic signed [CandW-1:0] cand_lo;
  logic signed [CandW-1:0] cand_hi;
  logic                    acc_lo;
  logic                    acc_hi;
  qprs_result_t            res;

  assign neg_p   = -$signed({{(CandW-PW){side_in.p[PW-1]}}, side_in.p});
  assign d_ext   = $signed({{(CandW-SqrtW){1'b0}}, d_in});
  assign tol_ext = $signed({{(CandW-TolW){1'b0}}, tolerance});
  assign cand_lo = neg_p - d_ext;
  assign cand_hi = neg_p + d_ext;
  assign acc_lo  = side_in.ok && (cand_lo > tol_ext);
  assign acc_hi  = side_in.ok && (cand_hi > tol_ext);

  // Accepted candidates fill the slots in order; empty slots read zero.
  always_comb begin
    res.count  = {1'b0, acc_lo} + {1'b0, acc_hi};
    res.root_a = '0;
    res.root_b = '0;
    if (acc_lo) begin
      res.root_a = cand_lo[RootW-1:0];
      if (acc_hi) begin
        res.root_b = cand_hi[RootW-1:0];
      end
    end else if (acc_hi) begin
      res.root_a = cand_hi[RootW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out <= res;
    end
  end

endmodule

/* verif/tb_top.sv */
// Self-checking bench for the positive root solver of t^2 + 2p*t + q = 0.
module tb_top;
  import qprs_pkg::*;

  // Cycles without any transfer on either channel before the run is declared hung.
  localparam int StallLimit = 5000;
  // Drain window; longer than the path from an input transfer to its result.
  localparam int DrainCycles = 40;
  // Length of the receiver hold-off used to fill the pipeline.
  localparam int HoldOffCycles = 300;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [TolW-1:0]      cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [PW-1:0] half_linear;
  logic signed [QW-1:0] constant_term;
  logic                 out_valid;
  logic                 out_stall;
  logic [CntW-1:0]      root_count;
  logic [RootW-1:0]     root_a;
  logic [RootW-1:0]     root_b;

  // Roots predicted for every accepted equation, oldest first.
  qprs_result_t    pending_roots[$];
  // Mirror of the tolerance register, tracked from the write port.
  logic [TolW-1:0] tol_model;
  int              mismatch_count;
  int              quiet_cycles;
  int              hold_cycles;
  int              sender_idle_pct;
  int              recv_idle_pct;

  quadratic_positive_root_solver_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .half_linear   (half_linear),
    .constant_term (constant_term),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .root_count    (root_count),
    .root_a        (root_a),
    .root_b        (root_b)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Integer square root, rounded down, built one result bit at a time from the top.
  // The discriminant stays below 2^48, so 24 result bits are enough.
  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = SqrtW - 1; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= x) begin
        r = trial;
      end
    end
    return r;
  endfunction

  // Predicts the packed roots for one equation under a given tolerance.
  // All arithmetic is done in 64 signed bits, which holds every intermediate.
  function automatic qprs_result_t solve_roots(input logic signed [PW-1:0] p,
                                               input logic signed [QW-1:0] q,
                                               input logic [TolW-1:0] tol);
    logic signed [63:0] pl;
    logic signed [63:0] ql;
    logic signed [63:0] tl;
    logic signed [63:0] delta;
    logic signed [63:0] d;
    logic signed [63:0] cand[2];
    qprs_result_t       res;
    int                 found;
    pl    = 64'(p);
    ql    = 64'(q);
    tl    = {48'd0, tol};
    delta = pl * pl - ql;
    res   = '0;
    found = 0;
    // The discriminant is compared with the tolerance moved up to Q24.24.
    if (delta >= tl * 4096) begin
      d       = floor_root(delta);
      cand[0] = -pl - d;
      cand[1] = -pl + d;
      // The smaller candidate is tried first; accepted roots fill the slots in order.
      for (int i = 0; i < 2; i++) begin
        if (cand[i] > tl) begin
          if (found == 0) begin
            res.root_a = cand[i][RootW-1:0];
          end else begin
            res.root_b = cand[i][RootW-1:0];
          end
          found++;
        end
      end
    end
    res.count = found[CntW-1:0];
    return res;
  endfunction

  // Scoreboard. Outputs are compared before the input transfer of the same edge is
  // recorded, and the tolerance mirror follows the write port after both. Everything
  // here reads values from just before the edge, so event ordering cannot matter.
  always @(posedge clk) begin : score_results
    qprs_result_t want;
    if (rst) begin
      tol_model = TolReset;
      pending_roots.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_roots.size() == 0) begin
          $error("result transfer with no equation outstanding: count %0d a %0h b %0h",
                 root_count, root_a, root_b);
          mismatch_count++;
        end else begin
          want = pending_roots.pop_front();
          if (root_count !== want.count) begin
            $error("root_count: expected %0d, got %0d", want.count, root_count);
            mismatch_count++;
          end
          if (root_a !== want.root_a) begin
            $error("root_a: expected %0h, got %0h", want.root_a, root_a);
            mismatch_count++;
          end
          if (root_b !== want.root_b) begin
            $error("root_b: expected %0h, got %0h", want.root_b, root_b);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_roots.push_back(solve_roots(half_linear, constant_term, tol_model));
      end
      if (cfg_we) begin
        tol_model = cfg_wdata;
      end
    end
  end

  // Receiver side. A requested hold-off keeps stall high for a counted stretch;
  // otherwise stall follows the current idle rate.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: a long run of cycles with no transfer at all means the block is hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[quadratic_positive_root_solver_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one equation and returns at the edge where it is transferred. Valid is left
  // high so back-to-back items need no extra assignment; callers lower it when done.
  task automatic send_equation(input logic signed [PW-1:0] p,
                               input logic signed [QW-1:0] q);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    half_linear   <= p;
    constant_term <= q;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // The tolerance is only changed once every outstanding result has come back. The
  // first edge lets the scoreboard record a transfer made at the edge we were called on.
  task automatic write_tolerance(input logic [TolW-1:0] value);
    @(posedge clk);
    while (pending_roots.size() != 0) begin
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Builds one random equation. Most are shaped so that roots exist and sit near the
  // interesting thresholds; the rest are raw noise over the full field ranges.
  task automatic pick_equation(output logic signed [PW-1:0] p,
                               output logic signed [QW-1:0] q);
    logic [63:0]        raw_p;
    logic [63:0]        raw_q;
    logic signed [63:0] p64;
    logic signed [63:0] q64;
    logic signed [63:0] d64;
    logic signed [63:0] tl64;
    int                 kind;
    int                 jit;
    tl64  = {48'd0, tol_model};
    raw_p = {$urandom(), $urandom()};
    raw_q = {$urandom(), $urandom()};
    kind  = $urandom_range(0, 19);
    jit   = $urandom_range(0, 4);
    jit   = jit - 2;
    if (kind < 4) begin
      // Noise over every bit of both fields.
      p64 = 64'($signed(raw_p[PW-1:0]));
      q64 = 64'($signed(raw_q[QW-1:0]));
    end else if (kind < 12) begin
      // Chosen roots -p +/- d at a random scale, slightly perturbed.
      d64 = 64'($urandom_range(0, 1 << $urandom_range(4, 22)));
      p64 = 64'($urandom_range(0, 1 << $urandom_range(4, 22)));
      if ($urandom_range(0, 3) != 0) begin
        p64 = -p64;
      end
      q64 = p64 * p64 - d64 * d64 + 64'(jit);
    end else if (kind < 15) begin
      // Discriminant right at the scaled tolerance.
      p64 = 64'($signed(raw_p[PW-1:0])) >>> $urandom_range(0, 20);
      q64 = p64 * p64 - tl64 * 4096 + 64'(jit);
    end else if (kind < 18) begin
      // Smaller candidate lands on the tolerance itself.
      d64 = 64'($urandom_range(16384, 1 << 22));
      p64 = -(tl64 + d64);
      q64 = p64 * p64 - d64 * d64 + 64'(jit);
    end else begin
      // Field extremes.
      case ($urandom_range(0, 4))
        0:       p64 = -(64'sd1 <<< (PW - 1));
        1:       p64 = (64'sd1 <<< (PW - 1)) - 1;
        2:       p64 = 0;
        3:       p64 = -1;
        default: p64 = 1;
      endcase
      case ($urandom_range(0, 4))
        0:       q64 = -(64'sd1 <<< (QW - 1));
        1:       q64 = (64'sd1 <<< (QW - 1)) - 1;
        2:       q64 = 0;
        3:       q64 = -1;
        default: q64 = 64'($signed(raw_q[QW-1:0]));
      endcase
    end
    p = p64[PW-1:0];
    q = q64[QW-1:0];
  endtask

  // Hand-picked equations under the reset tolerance of 1 (Q4.12).
  task automatic test_reset_tolerance();
    send_equation(24'sd0, 48'sd0);                  // zero discriminant, below tolerance
    send_equation(-24'sd12288, 48'sd33554432);      // t^2 - 6t + 2: two positive roots
    send_equation(24'sd12288, 48'sd33554432);       // both roots negative
    send_equation(-24'sd8192, -48'sd83886080);      // first candidate rejected, root 5.0
    send_equation(24'sd0, -48'sd4096);              // discriminant equal to the tolerance
    send_equation(24'sd0, -48'sd4095);              // discriminant one below the tolerance
    send_equation(-24'sd65, 48'sd129);              // smaller candidate equals the tolerance
    send_equation(-24'sd8388608, -48'sd140737488355328);  // largest discriminant
    send_equation(24'sd8388607, -48'sd140737488355328);
    send_equation(-24'sd8388608, 48'sd140737488355327);   // hugely negative discriminant
    send_equation(-24'sd8388608, 48'sd0);           // smaller root exactly zero
    send_equation(24'sd1, 48'sd140737488355327);
    send_equation(-24'sd1, 48'sd0);
    in_valid <= 1'b0;
  endtask

  // With a zero tolerance a root must still be strictly positive.
  task automatic test_zero_tolerance();
    write_tolerance(16'd0);
    send_equation(24'sd0, 48'sd0);
    send_equation(-24'sd1, 48'sd0);
    send_equation(-24'sd4096, 48'sd0);
    send_equation(24'sd0, -48'sd1);
    in_valid <= 1'b0;
  endtask

  // Largest tolerance: the threshold rejects roots that would pass otherwise.
  task automatic test_max_tolerance();
    write_tolerance(16'hFFFF);
    send_equation(-24'sd8388608, -48'sd140737488355328);
    send_equation(24'sd0, -48'sd268431360);
    send_equation(-24'sd81919, 48'sd6442450944);
    in_valid <= 1'b0;
  endtask

  // A stream of random equations under one tolerance and one pair of idle rates.
  task automatic test_random_stream(input logic [TolW-1:0] tol, input int snd_pct,
                                    input int rcv_pct, input int count);
    logic signed [PW-1:0] p;
    logic signed [QW-1:0] q;
    write_tolerance(tol);
    sender_idle_pct <= snd_pct;
    recv_idle_pct   <= rcv_pct;
    for (int i = 0; i < count; i++) begin
      pick_equation(p, q);
      send_equation(p, q);
    end
    in_valid <= 1'b0;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so the
  // pipeline fills and the input channel has to stall.
  task automatic test_backpressure();
    logic signed [PW-1:0] p;
    logic signed [QW-1:0] q;
    write_tolerance(16'd1);
    sender_idle_pct <= 0;
    recv_idle_pct   <= 0;
    hold_cycles     <= HoldOffCycles;
    for (int i = 0; i < 120; i++) begin
      pick_equation(p, q);
      send_equation(p, q);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    half_linear     <= '0;
    constant_term   <= '0;
    out_stall       <= 1'b0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    hold_cycles     = 0;
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_tolerance();
    test_zero_tolerance();
    test_max_tolerance();
    // Sender idles a quarter of the time, receiver most of the time, then reversed,
    // then both run flat out, then the first pair of rates again with a small tolerance.
    test_random_stream(16'($urandom_range(1, 65534)), 24, 79, 400);
    test_random_stream(16'hFFFF, 79, 24, 300);
    test_random_stream(16'd0, 0, 0, 300);
    test_random_stream(16'($urandom_range(1, 4096)), 24, 79, 150);
    test_backpressure();

    while (pending_roots.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[quadratic_positive_root_solver_core] OK");
    end else begin
      $display("[quadratic_positive_root_solver_core] ERROR");
    end
    $finish;
  end

endmodule
